>>> rtl/bfss_pkg.sv
package bfss_pkg;

   // default sizes handed to the top level
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int DEF_MAX_KERNEL = 15;
   localparam int DEF_CHANNELS   = 4;

   // fixed field widths
   localparam int SAMPLE_W   = 8;
   localparam int OUT_ROW_W  = 12;
   localparam int OUT_COL_W  = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;
   localparam int IMG_W_W    = 11;
   localparam int IMG_H_W    = 13;
   localparam int KER_W      = 4;
   localparam int PORT_CHANS = 4;

   // register reset values
   localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH  = IMG_W_W'(640);
   localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT = IMG_H_W'(480);
   localparam logic [KER_W-1:0]   RST_KERNEL       = KER_W'(3);
   localparam logic [KER_W-1:0]   RST_ANCHOR       = KER_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_KERNEL_WIDTH,
      CSR_KERNEL_HEIGHT,
      CSR_ANCHOR_COL,
      CSR_ANCHOR_ROW,
      CSR_NORMALIZE,
      CSR_BORDER_MODE
   } csr_index_type;

   typedef enum logic [1:0] {
      BORDER_ZERO,
      BORDER_REPLICATE,
      BORDER_REFLECT,
      BORDER_REFLECT101
   } border_type;

   typedef enum logic {
      OP_PIXEL,
      OP_DRAIN
   } opcode_type;

endpackage

>>> rtl/box_filter_sliding_sum.sv
// channel | direction | ports                                   | accepted when
// req     | in        | req_opcode, req_in_chan0..3             | req_valid & req_ready
// rsp     | out       | rsp_out_chan0..3, rsp_out_row/col, ...  | rsp_valid & rsp_ready
// csr     | in        | csr_index, csr_data                     | csr_valid & csr_ready
//
// an item that releases no pixel passes through the position, update and check states only;
// one that releases a pixel also walks to the corner of the box, reads every tap and, with
// normalize on, runs a bit-serial divide; the single read port of the line store is visited once per tap.
// reset clears control state only; the line store holds no reset value.
// a finished pixel waits in the output register while the next item is taken;
// a stalled output only holds the block when another pixel is ready to leave.
module box_filter_sliding_sum import bfss_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_KERNEL = DEF_MAX_KERNEL,
   parameter int CHANNELS   = DEF_CHANNELS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_opcode,
   input  logic [SAMPLE_W-1:0]   req_in_chan0,
   input  logic [SAMPLE_W-1:0]   req_in_chan1,
   input  logic [SAMPLE_W-1:0]   req_in_chan2,
   input  logic [SAMPLE_W-1:0]   req_in_chan3,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SAMPLE_W-1:0]   rsp_out_chan0,
   output logic [SAMPLE_W-1:0]   rsp_out_chan1,
   output logic [SAMPLE_W-1:0]   rsp_out_chan2,
   output logic [SAMPLE_W-1:0]   rsp_out_chan3,
   output logic [OUT_ROW_W-1:0]  rsp_out_row,
   output logic [OUT_COL_W-1:0]  rsp_out_col,
   output logic                  rsp_frame_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int CLW = $clog2(MAX_WIDTH);
   localparam int KB  = $clog2(MAX_KERNEL + 1);
   localparam int AW  = 2 * KB;
   localparam int SW  = $clog2(255 * MAX_KERNEL * MAX_KERNEL + 1);
   localparam int LW  = (WW > HW) ? WW : HW;
   localparam int PSW = LW + 2;
   localparam int RB  = $clog2(2 * MAX_KERNEL + 2);
   localparam int AB  = RB + CLW;
   localparam int DEPTH = 2 ** AB;
   localparam int PW  = $clog2(2 * MAX_WIDTH * (MAX_HEIGHT + 1));
   localparam int DCW = $clog2(SW + 1);
   localparam int DW  = SAMPLE_W * CHANNELS;

   typedef enum logic [3:0] {
      S_IDLE, S_POS, S_UPD, S_POS2, S_CHK, S_PREC, S_PRER, S_TAPS, S_ACC, S_DIV, S_OUT
   } state_type;

   // one step of a reflecting walk along a dimension of length len
   function automatic logic [LW:0] walk_step(input logic [LW-1:0] m, input logic d,
                                             input logic [LW-1:0] len, input logic r101);
      logic [LW-1:0] mn;
      logic dn;
      mn = m;
      dn = d;
      if (len == LW'(1)) begin
         mn = '0;
      end else if (d) begin
         if (m == len - LW'(1)) begin
            mn = r101 ? m - LW'(1) : m;
            dn = 1'b0;
         end else begin
            mn = m + LW'(1);
         end
      end else begin
         if (m == '0) begin
            mn = r101 ? LW'(1) : '0;
            dn = 1'b1;
         end else begin
            mn = m - LW'(1);
         end
      end
      return {dn, mn};
   endfunction

   // tap position to {valid, index} under the border mode
   function automatic logic [LW:0] map_tap(input logic signed [PSW-1:0] p,
                                           input logic [LW-1:0] m, input logic [LW-1:0] len,
                                           input border_type mode);
      logic inr;
      logic [LW-1:0] idx;
      inr = (p >= 0) && (p < $signed({2'b00, len}));
      if (mode == BORDER_REFLECT || mode == BORDER_REFLECT101) begin
         idx = m;
      end else if (p < 0) begin
         idx = '0;
      end else if (!inr) begin
         idx = len - LW'(1);
      end else begin
         idx = p[LW-1:0];
      end
      return {(mode != BORDER_ZERO) || inr, idx};
   endfunction

   // configuration registers
   logic [IMG_W_W-1:0] cfg_w_ff;
   logic [IMG_H_W-1:0] cfg_h_ff;
   logic [KER_W-1:0]   cfg_kw_ff, cfg_kh_ff, cfg_ax_ff, cfg_ay_ff;
   logic               cfg_norm_ff;
   border_type         cfg_border_ff;

   // effective geometry
   logic [WW-1:0] g_w_ff, g_w_in, g_lc_ff, g_lc_in;
   logic [HW-1:0] g_h_ff, g_h_in, g_lr_ff, g_lr_in;
   logic [KB-1:0] g_kw_ff, g_kw_in, g_kh_ff, g_kh_in, g_ax_ff, g_ax_in, g_ay_ff, g_ay_in;
   logic [AW-1:0] g_area_ff, g_area_in;

   state_type state_ff, state_in;
   logic [HW-1:0]  in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [CLW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic           op_ff, op_in;
   logic [DW-1:0]  pix_ff, pix_in;
   logic [PW-1:0]  in_pos_ff, in_pos_in, out_pos_ff, out_pos_in;
   logic [PW-1:0]  total_ff, total_in, lag_ff, lag_in;
   logic           last_ff, last_in;

   // tap walkers
   logic signed [PSW-1:0] cp_ff, cp_in, rp_ff, rp_in, csp_ff, csp_in;
   logic [LW-1:0] cm_ff, cm_in, rm_ff, rm_in, csm_ff, csm_in;
   logic          cd_ff, cd_in, rd_ff, rd_in, csd_ff, csd_in;
   logic [KB-1:0] cnt_ff, cnt_in, j_ff, j_in, i_ff, i_in;
   logic          tapv_ff, tapv_in, accen_ff, accen_in;

   // sums and divider
   logic [SW-1:0] acc_ff [CHANNELS];
   logic [SW-1:0] acc_in [CHANNELS];
   logic [AW-1:0] rem_ff [CHANNELS];
   logic [AW-1:0] rem_in [CHANNELS];
   logic [DCW-1:0] div_ff, div_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_chan_ff [PORT_CHANS];
   logic [SAMPLE_W-1:0] rsp_chan_in [PORT_CHANS];
   logic [HW-1:0]       rsp_row_ff, rsp_row_in;
   logic [CLW-1:0]      rsp_col_ff, rsp_col_in;
   logic                rsp_last_ff, rsp_last_in;

   // line store
   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] mem_q_ff;
   logic          mem_we, mem_re;
   logic [AB-1:0] mem_waddr, mem_raddr;

   logic [SAMPLE_W-1:0] req_chan [PORT_CHANS];
   logic [PW-1:0]       in_pos_c, out_pos_c, total_c, lag_c;
   logic [KB-1:0]       br_c, rr_c, lrm_c, lcm_c;
   logic [LW:0]         col_tap, row_tap, col_nxt, row_nxt;
   logic                r101;

   assign req_chan[0] = req_in_chan0;
   assign req_chan[1] = req_in_chan1;
   assign req_chan[2] = req_in_chan2;
   assign req_chan[3] = req_in_chan3;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_chan0 = rsp_chan_ff[0];
   assign rsp_out_chan1 = rsp_chan_ff[1];
   assign rsp_out_chan2 = rsp_chan_ff[2];
   assign rsp_out_chan3 = rsp_chan_ff[3];
   assign rsp_out_row = OUT_ROW_W'(rsp_row_ff);
   assign rsp_out_col = OUT_COL_W'(rsp_col_ff);
   assign rsp_frame_last = rsp_last_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff      <= RST_IMAGE_WIDTH;
         cfg_h_ff      <= RST_IMAGE_HEIGHT;
         cfg_kw_ff     <= RST_KERNEL;
         cfg_kh_ff     <= RST_KERNEL;
         cfg_ax_ff     <= RST_ANCHOR;
         cfg_ay_ff     <= RST_ANCHOR;
         cfg_norm_ff   <= 1'b1;
         cfg_border_ff <= BORDER_REFLECT101;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   cfg_w_ff      <= csr_data[IMG_W_W-1:0];
            CSR_IMAGE_HEIGHT:  cfg_h_ff      <= csr_data[IMG_H_W-1:0];
            CSR_KERNEL_WIDTH:  cfg_kw_ff     <= csr_data[KER_W-1:0];
            CSR_KERNEL_HEIGHT: cfg_kh_ff     <= csr_data[KER_W-1:0];
            CSR_ANCHOR_COL:    cfg_ax_ff     <= csr_data[KER_W-1:0];
            CSR_ANCHOR_ROW:    cfg_ay_ff     <= csr_data[KER_W-1:0];
            CSR_NORMALIZE:     cfg_norm_ff   <= csr_data[0];
            CSR_BORDER_MODE:   cfg_border_ff <= border_type'(csr_data[1:0]);
            default: ;
         endcase
      end
   end

   // effective geometry from the registers
   always_comb begin
      if (cfg_w_ff == '0) g_w_in = WW'(1);
      else if (int'(cfg_w_ff) > MAX_WIDTH) g_w_in = WW'(MAX_WIDTH);
      else g_w_in = WW'(cfg_w_ff);
      if (cfg_h_ff == '0) g_h_in = HW'(1);
      else if (int'(cfg_h_ff) > MAX_HEIGHT) g_h_in = HW'(MAX_HEIGHT);
      else g_h_in = HW'(cfg_h_ff);
      if (cfg_kw_ff == '0) g_kw_in = KB'(1);
      else if (int'(cfg_kw_ff) > MAX_KERNEL) g_kw_in = KB'(MAX_KERNEL);
      else g_kw_in = KB'(cfg_kw_ff);
      if (cfg_kh_ff == '0) g_kh_in = KB'(1);
      else if (int'(cfg_kh_ff) > MAX_KERNEL) g_kh_in = KB'(MAX_KERNEL);
      else g_kh_in = KB'(cfg_kh_ff);
      g_ax_in = (int'(cfg_ax_ff) < int'(g_kw_in)) ? KB'(cfg_ax_ff) : (g_kw_in >> 1);
      g_ay_in = (int'(cfg_ay_ff) < int'(g_kh_in)) ? KB'(cfg_ay_ff) : (g_kh_in >> 1);
      br_c  = g_kh_in - KB'(1) - g_ay_in;
      rr_c  = g_kw_in - KB'(1) - g_ax_in;
      lrm_c = (br_c > g_ay_in) ? br_c : g_ay_in;
      lcm_c = (rr_c > g_ax_in) ? rr_c : g_ax_in;
      g_lr_in = (int'(lrm_c) > int'(g_h_in) - 1) ? g_h_in - HW'(1) : HW'(lrm_c);
      g_lc_in = (int'(lcm_c) > int'(g_w_in) - 1) ? g_w_in - WW'(1) : WW'(lcm_c);
      g_area_in = AW'(g_kw_in) * AW'(g_kh_in);
   end

   always_ff @(posedge clock) begin
      g_w_ff    <= g_w_in;
      g_h_ff    <= g_h_in;
      g_kw_ff   <= g_kw_in;
      g_kh_ff   <= g_kh_in;
      g_ax_ff   <= g_ax_in;
      g_ay_ff   <= g_ay_in;
      g_lr_ff   <= g_lr_in;
      g_lc_ff   <= g_lc_in;
      g_area_ff <= g_area_in;
   end

   // raster positions
   assign in_pos_c  = PW'(in_row_ff) * PW'(g_w_ff) + PW'(in_col_ff);
   assign out_pos_c = PW'(out_row_ff) * PW'(g_w_ff) + PW'(out_col_ff);
   assign total_c   = PW'(g_h_ff) * PW'(g_w_ff);
   assign lag_c     = PW'(g_lr_ff) * PW'(g_w_ff) + PW'(g_lc_ff);

   // current taps and next walker steps
   assign r101    = (cfg_border_ff == BORDER_REFLECT101);
   assign col_tap = map_tap(cp_ff, cm_ff, LW'(g_w_ff), cfg_border_ff);
   assign row_tap = map_tap(rp_ff, rm_ff, LW'(g_h_ff), cfg_border_ff);
   assign col_nxt = walk_step(cm_ff, cd_ff, LW'(g_w_ff), r101);
   assign row_nxt = walk_step(rm_ff, rd_ff, LW'(g_h_ff), r101);

   // sequencer
   always_comb begin
      logic          done;
      logic [HW-1:0] row_eff;
      logic [CLW-1:0] col_eff;
      logic [PW-1:0] pos_eff;
      logic [AW:0]   trial;
      logic [SW:0]   q;
      logic [AW:0]   rem2;
      state_in   = state_ff;
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      op_in      = op_ff;
      pix_in     = pix_ff;
      in_pos_in  = in_pos_ff;
      out_pos_in = out_pos_ff;
      total_in   = total_ff;
      lag_in     = lag_ff;
      last_in    = last_ff;
      cp_in = cp_ff;  cm_in = cm_ff;  cd_in = cd_ff;
      rp_in = rp_ff;  rm_in = rm_ff;  rd_in = rd_ff;
      csp_in = csp_ff; csm_in = csm_ff; csd_in = csd_ff;
      cnt_in = cnt_ff; j_in = j_ff; i_in = i_ff;
      tapv_in  = 1'b0;
      accen_in = 1'b0;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_chan_in  = rsp_chan_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = {RB'(in_row_ff), in_col_ff};
      mem_raddr = {RB'(row_tap[LW-1:0]), CLW'(col_tap[LW-1:0])};
      done    = 1'b0;
      row_eff = in_row_ff;
      col_eff = in_col_ff;
      pos_eff = in_pos_ff;
      trial   = '0;
      q       = '0;
      rem2    = '0;

      // accumulate the tap read in the previous cycle
      if (accen_ff) begin
         for (int c = 0; c < CHANNELS; c++) begin
            if (tapv_ff) begin
               acc_in[c] = acc_ff[c] + SW'(mem_q_ff[c*SAMPLE_W +: SAMPLE_W]);
            end
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_opcode;
               for (int c = 0; c < CHANNELS; c++) begin
                  pix_in[c*SAMPLE_W +: SAMPLE_W] = req_chan[c];
               end
               state_in = S_POS;
            end
         end
         S_POS, S_POS2: begin
            in_pos_in  = in_pos_c;
            out_pos_in = out_pos_c;
            total_in   = total_c;
            lag_in     = lag_c;
            state_in   = (state_ff == S_POS) ? S_UPD : S_CHK;
         end
         S_UPD: begin
            // frame end returns the counters to zero
            done = (in_pos_ff >= total_ff) && (out_pos_ff >= total_ff);
            if (done) begin
               row_eff    = '0;
               col_eff    = '0;
               pos_eff    = '0;
               out_row_in = '0;
               out_col_in = '0;
            end
            in_row_in = row_eff;
            in_col_in = col_eff;
            if (op_ff == OP_PIXEL && pos_eff < total_ff) begin
               mem_we    = 1'b1;
               mem_waddr = {RB'(row_eff), col_eff};
               if (WW'(col_eff) + WW'(1) >= g_w_ff) begin
                  in_col_in = '0;
                  in_row_in = row_eff + HW'(1);
               end else begin
                  in_col_in = col_eff + CLW'(1);
               end
            end
            state_in = S_POS2;
         end
         S_CHK: begin
            if (out_pos_ff < total_ff &&
                (in_pos_ff >= total_ff || out_pos_ff + lag_ff < in_pos_ff)) begin
               last_in = (out_pos_ff + PW'(1) == total_ff);
               cp_in  = PSW'(out_col_ff);
               cm_in  = LW'(out_col_ff);
               cd_in  = 1'b0;
               rp_in  = PSW'(out_row_ff);
               rm_in  = LW'(out_row_ff);
               rd_in  = 1'b0;
               cnt_in = g_ax_ff;
               for (int c = 0; c < CHANNELS; c++) acc_in[c] = '0;
               state_in = S_PREC;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PREC: begin
            // walk the column back to the left edge of the box
            if (cnt_ff == '0) begin
               csp_in = cp_ff;
               csm_in = cm_ff;
               csd_in = !cd_ff;
               cd_in  = !cd_ff;
               cnt_in = g_ay_ff;
               state_in = S_PRER;
            end else begin
               cp_in  = cp_ff - PSW'(1);
               cm_in  = col_nxt[LW-1:0];
               cd_in  = col_nxt[LW];
               cnt_in = cnt_ff - KB'(1);
            end
         end
         S_PRER: begin
            // walk the row back to the top edge of the box
            if (cnt_ff == '0) begin
               rd_in = !rd_ff;
               j_in  = '0;
               i_in  = '0;
               state_in = S_TAPS;
            end else begin
               rp_in  = rp_ff - PSW'(1);
               rm_in  = row_nxt[LW-1:0];
               rd_in  = row_nxt[LW];
               cnt_in = cnt_ff - KB'(1);
            end
         end
         S_TAPS: begin
            // one line store read per tap
            mem_re   = 1'b1;
            tapv_in  = col_tap[LW] && row_tap[LW];
            accen_in = 1'b1;
            if (j_ff == g_kw_ff - KB'(1)) begin
               j_in  = '0;
               cp_in = csp_ff;
               cm_in = csm_ff;
               cd_in = csd_ff;
               if (i_ff == g_kh_ff - KB'(1)) begin
                  state_in = S_ACC;
               end else begin
                  i_in  = i_ff + KB'(1);
                  rp_in = rp_ff + PSW'(1);
                  rm_in = row_nxt[LW-1:0];
                  rd_in = row_nxt[LW];
               end
            end else begin
               j_in  = j_ff + KB'(1);
               cp_in = cp_ff + PSW'(1);
               cm_in = col_nxt[LW-1:0];
               cd_in = col_nxt[LW];
            end
         end
         S_ACC: begin
            for (int c = 0; c < CHANNELS; c++) rem_in[c] = '0;
            div_in   = '0;
            state_in = cfg_norm_ff ? S_DIV : S_OUT;
         end
         S_DIV: begin
            // restoring divide, one quotient bit per cycle
            for (int c = 0; c < CHANNELS; c++) begin
               trial = {rem_ff[c], acc_ff[c][SW-1]};
               if (trial >= {1'b0, g_area_ff}) begin
                  rem_in[c] = AW'(trial - {1'b0, g_area_ff});
                  acc_in[c] = {acc_ff[c][SW-2:0], 1'b1};
               end else begin
                  rem_in[c] = AW'(trial);
                  acc_in[c] = {acc_ff[c][SW-2:0], 1'b0};
               end
            end
            div_in = div_ff + DCW'(1);
            if (div_ff == DCW'(SW - 1)) state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = out_row_ff;
               rsp_col_in   = out_col_ff;
               rsp_last_in  = last_ff;
               for (int c = 0; c < PORT_CHANS; c++) begin
                  rsp_chan_in[c] = '0;
                  if (c < CHANNELS) begin
                     q = {1'b0, acc_ff[c]};
                     if (cfg_norm_ff) begin
                        // round to nearest, ties to even
                        rem2 = {rem_ff[c], 1'b0};
                        if (rem2 > {1'b0, g_area_ff} ||
                            (rem2 == {1'b0, g_area_ff} && acc_ff[c][0])) begin
                           q = q + (SW+1)'(1);
                        end
                     end
                     rsp_chan_in[c] = (q > (SW+1)'(255)) ? SAMPLE_W'(255) : SAMPLE_W'(q);
                  end
               end
               if (WW'(out_col_ff) + WW'(1) >= g_w_ff) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + HW'(1);
               end else begin
                  out_col_in = out_col_ff + CLW'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         tapv_ff      <= 1'b0;
         accen_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         tapv_ff      <= tapv_in;
         accen_ff     <= accen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      pix_ff     <= pix_in;
      in_pos_ff  <= in_pos_in;
      out_pos_ff <= out_pos_in;
      total_ff   <= total_in;
      lag_ff     <= lag_in;
      last_ff    <= last_in;
      cp_ff  <= cp_in;  cm_ff  <= cm_in;  cd_ff  <= cd_in;
      rp_ff  <= rp_in;  rm_ff  <= rm_in;  rd_ff  <= rd_in;
      csp_ff <= csp_in; csm_ff <= csm_in; csd_ff <= csd_in;
      cnt_ff <= cnt_in;
      j_ff   <= j_in;
      i_ff   <= i_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      rsp_chan_ff <= rsp_chan_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_last_ff <= rsp_last_in;
   end

   // line store: ring of rows, one write or one read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= pix_ff;
      if (mem_re) mem_q_ff <= mem[mem_raddr];
   end

endmodule

>>> rtl/bfss_checker.sv
module bfss_checker import bfss_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [OUT_ROW_W-1:0] rsp_out_row,
   input logic [OUT_COL_W-1:0] rsp_out_col
);

   // a pending pixel stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the item was taken");

   // a pending pixel keeps its position
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_row) && $stable(rsp_out_col))
      else $error("rsp position changed while stalled");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in work");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a taken item does not make a pixel appear at once
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared one cycle after an item was taken");

endmodule

bind box_filter_sliding_sum bfss_checker u_bfss_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_out_row (rsp_out_row),
   .rsp_out_col (rsp_out_col)
);
